// File: rtl/core/lsbe_pkg.sv
// Shared types, constants and vertex table for the line segment box extruder.
`timescale 1ns / 1ps
`default_nettype none

package lsbe_pkg;

    localparam logic [13:0] CapLimit  = 14'd12800;
    localparam logic [15:0] WidthRst  = 16'd2560;
    localparam logic [3:0]  CapVerts  = 4'd5;
    localparam logic [3:0]  LastSlot  = 4'd12;
    localparam logic [4:0]  SqrtIters = 5'd16;
    localparam logic [3:0]  DivIters  = 4'd9;

    typedef struct packed {
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [31:0] start_z;
        logic [31:0] end_x;
        logic [31:0] end_y;
        logic [31:0] end_z;
        logic        is_first;
    } t_in;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [1:0]  tex_u;
        logic        tex_v;
        logic [3:0]  vertex_number;
        logic        last;
    } t_out;

    typedef logic [2:0][34:0] t_vec;
    typedef logic [2:0][17:0] t_unit;
    typedef logic [2:0][31:0] t_pt3;

    typedef struct packed {
        t_pt3        st;
        t_pt3        en;
        logic        first;
        t_unit       f;
        t_unit       r;
        logic [13:0] off;
    } t_job;

    typedef enum logic [1:0] {PT_START, PT_BASE, PT_END} t_pt_sel;
    typedef enum logic [1:0] {SG_ZERO, SG_POS, SG_NEG} t_sgn;

    typedef struct packed {
        t_pt_sel    pt;
        t_sgn       su;
        t_sgn       sr;
        logic [1:0] tu;
        logic       tv;
    } t_vtx;

    // slots 0..4 are the arrow cap, 5..12 the box
    function automatic t_vtx vtx_info(input logic [3:0] slot);
        t_vtx v;
        case (slot)
            4'd0:    v = '{PT_START, SG_ZERO, SG_ZERO, 2'd1, 1'b0};
            4'd1:    v = '{PT_BASE,  SG_POS,  SG_NEG,  2'd0, 1'b1};
            4'd2:    v = '{PT_BASE,  SG_POS,  SG_POS,  2'd2, 1'b1};
            4'd3:    v = '{PT_BASE,  SG_NEG,  SG_NEG,  2'd0, 1'b1};
            4'd4:    v = '{PT_BASE,  SG_NEG,  SG_POS,  2'd2, 1'b1};
            4'd5:    v = '{PT_BASE,  SG_POS,  SG_NEG,  2'd0, 1'b0};
            4'd6:    v = '{PT_BASE,  SG_POS,  SG_POS,  2'd2, 1'b0};
            4'd7:    v = '{PT_END,   SG_POS,  SG_NEG,  2'd0, 1'b1};
            4'd8:    v = '{PT_END,   SG_POS,  SG_POS,  2'd2, 1'b1};
            4'd9:    v = '{PT_BASE,  SG_NEG,  SG_NEG,  2'd0, 1'b0};
            4'd10:   v = '{PT_BASE,  SG_NEG,  SG_POS,  2'd2, 1'b0};
            4'd11:   v = '{PT_END,   SG_NEG,  SG_NEG,  2'd0, 1'b1};
            4'd12:   v = '{PT_END,   SG_NEG,  SG_POS,  2'd2, 1'b1};
            default: v = '{PT_START, SG_ZERO, SG_ZERO, 2'd0, 1'b0};
        endcase
        return v;
    endfunction

    // round(v / 2^sh), half away from zero
    function automatic logic [17:0] rnd_shr(input logic [35:0] v, input logic [4:0] sh);
        logic [35:0] mag;
        logic [35:0] m;
        mag = v[35] ? (~v + 36'd1) : v;
        m   = (mag + (36'd1 << (sh - 5'd1))) >> sh;
        return v[35] ? (~m[17:0] + 18'd1) : m[17:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/lsbe_norm.sv
// Vector normalizer: magnitude, scale, squares, iterative sqrt and divide.
`timescale 1ns / 1ps
`default_nettype none

module lsbe_norm (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  lsbe_pkg::t_job  i_job,
    input  lsbe_pkg::t_vec  i_vec,
    output logic            o_valid,
    input  logic            i_ready,
    output lsbe_pkg::t_job  o_job,
    output lsbe_pkg::t_unit o_res,
    output logic [30:0]     o_len,
    output logic [2:0]      o_shift
);
    import lsbe_pkg::*;

    logic adv, sq_free, sq_load, sq_hand, dv_free, dv_take;

    logic             r_p1_v;
    t_job             r_p1_job;
    logic [2:0][34:0] r_p1_m;
    logic [2:0]       r_p1_neg;

    logic             r_p2_v;
    t_job             r_p2_job;
    logic [2:0][29:0] r_p2_a;
    logic [2:0]       r_p2_neg;
    logic [2:0]       r_p2_s;

    logic             r_p3_v;
    t_job             r_p3_job;
    logic [2:0][29:0] r_p3_a;
    logic [2:0]       r_p3_neg;
    logic [2:0]       r_p3_s;
    logic [2:0][59:0] r_p3_sq;

    logic             r_p4_v;
    t_job             r_p4_job;
    logic [2:0][29:0] r_p4_a;
    logic [2:0]       r_p4_neg;
    logic [2:0]       r_p4_s;
    logic [61:0]      r_p4_sum;

    logic             r_sq_v;
    logic [4:0]       r_sq_cnt;
    logic [63:0]      r_sq_n;
    logic [35:0]      r_sq_rem;
    logic [31:0]      r_sq_root;
    t_job             r_sq_job;
    logic [2:0][29:0] r_sq_a;
    logic [2:0]       r_sq_neg;
    logic [2:0]       r_sq_s;

    logic             r_dv_v;
    logic [3:0]       r_dv_cnt;
    logic [2:0][31:0] r_dv_rem;
    logic [2:0][17:0] r_dv_n;
    logic [2:0][17:0] r_dv_q;
    logic [30:0]      r_dv_len;
    t_job             r_dv_job;
    logic [2:0]       r_dv_neg;
    logic [2:0]       r_dv_s;

    logic [2:0][34:0] in_m;
    logic [34:0]      p1_mx;
    logic [2:0]       n_s;
    logic [34:0]      p1_sh;
    logic [2:0][29:0] n_a;

    logic [63:0]      n_sq_n;
    logic [35:0]      n_sq_rem;
    logic [31:0]      n_sq_root;
    logic [35:0]      sq_rem2;
    logic [35:0]      sq_trial;

    logic [2:0][46:0] dv_num;
    logic [2:0][31:0] n_dv_rem;
    logic [2:0][17:0] n_dv_n;
    logic [2:0][17:0] n_dv_q;
    logic [31:0]      dv_rem2;

    assign o_valid = r_dv_v && (r_dv_cnt == 4'd0);
    assign dv_take = o_valid && i_ready;
    assign dv_free = !r_dv_v || dv_take;
    assign sq_hand = r_sq_v && (r_sq_cnt == 5'd0) && dv_free;
    assign sq_free = !r_sq_v || sq_hand;
    assign sq_load = r_p4_v && sq_free;
    assign adv     = !r_p4_v || sq_load;
    assign o_ready = adv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_m[i] = i_vec[i][34] ? (~i_vec[i] + 35'd1) : i_vec[i];
        end
    end

    // smallest shift that brings the largest magnitude under 2^30
    always_comb begin
        p1_mx = r_p1_m[0];
        if (r_p1_m[1] > p1_mx) p1_mx = r_p1_m[1];
        if (r_p1_m[2] > p1_mx) p1_mx = r_p1_m[2];
        if (p1_mx[34])      n_s = 3'd5;
        else if (p1_mx[33]) n_s = 3'd4;
        else if (p1_mx[32]) n_s = 3'd3;
        else if (p1_mx[31]) n_s = 3'd2;
        else if (p1_mx[30]) n_s = 3'd1;
        else                n_s = 3'd0;
        p1_sh = '0;
        for (int i = 0; i < 3; i++) begin
            p1_sh  = r_p1_m[i] >> n_s;
            n_a[i] = p1_sh[29:0];
        end
    end

    // two root bits per cycle
    always_comb begin
        n_sq_rem  = r_sq_rem;
        n_sq_root = r_sq_root;
        n_sq_n    = r_sq_n;
        sq_rem2   = '0;
        sq_trial  = '0;
        for (int j = 0; j < 2; j++) begin
            sq_rem2  = {n_sq_rem[33:0], n_sq_n[63:62]};
            sq_trial = {2'b00, n_sq_root, 2'b01};
            n_sq_n   = {n_sq_n[61:0], 2'b00};
            if (sq_rem2 >= sq_trial) begin
                n_sq_rem  = sq_rem2 - sq_trial;
                n_sq_root = {n_sq_root[30:0], 1'b1};
            end else begin
                n_sq_rem  = sq_rem2;
                n_sq_root = {n_sq_root[30:0], 1'b0};
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            dv_num[i] = {1'b0, r_sq_a[i], 16'd0} + {17'd0, r_sq_root[30:1]};
        end
    end

    // two quotient bits per cycle in each lane
    always_comb begin
        n_dv_rem = r_dv_rem;
        n_dv_n   = r_dv_n;
        n_dv_q   = r_dv_q;
        dv_rem2  = '0;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 2; j++) begin
                dv_rem2   = {n_dv_rem[i][30:0], n_dv_n[i][17]};
                n_dv_n[i] = {n_dv_n[i][16:0], 1'b0};
                if (dv_rem2 >= {1'b0, r_dv_len}) begin
                    n_dv_rem[i] = dv_rem2 - {1'b0, r_dv_len};
                    n_dv_q[i]   = {n_dv_q[i][16:0], 1'b1};
                end else begin
                    n_dv_rem[i] = dv_rem2;
                    n_dv_q[i]   = {n_dv_q[i][16:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else if (adv) begin
            r_p1_v   <= i_valid;
            r_p1_job <= i_job;
            r_p1_m   <= in_m;
            for (int i = 0; i < 3; i++) r_p1_neg[i] <= i_vec[i][34];

            r_p2_v   <= r_p1_v;
            r_p2_job <= r_p1_job;
            r_p2_a   <= n_a;
            r_p2_neg <= r_p1_neg;
            r_p2_s   <= n_s;

            r_p3_v   <= r_p2_v;
            r_p3_job <= r_p2_job;
            r_p3_a   <= r_p2_a;
            r_p3_neg <= r_p2_neg;
            r_p3_s   <= r_p2_s;
            for (int i = 0; i < 3; i++) r_p3_sq[i] <= r_p2_a[i] * r_p2_a[i];

            r_p4_v   <= r_p3_v;
            r_p4_job <= r_p3_job;
            r_p4_a   <= r_p3_a;
            r_p4_neg <= r_p3_neg;
            r_p4_s   <= r_p3_s;
            r_p4_sum <= {2'b00, r_p3_sq[0]} + {2'b00, r_p3_sq[1]} + {2'b00, r_p3_sq[2]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v   <= 1'b0;
            r_sq_cnt <= '0;
        end else if (sq_load) begin
            r_sq_v    <= 1'b1;
            r_sq_cnt  <= SqrtIters;
            r_sq_n    <= {2'b00, r_p4_sum};
            r_sq_rem  <= '0;
            r_sq_root <= '0;
            r_sq_job  <= r_p4_job;
            r_sq_a    <= r_p4_a;
            r_sq_neg  <= r_p4_neg;
            r_sq_s    <= r_p4_s;
        end else if (sq_hand) begin
            r_sq_v <= 1'b0;
        end else if (r_sq_v && (r_sq_cnt != 5'd0)) begin
            r_sq_cnt  <= r_sq_cnt - 5'd1;
            r_sq_n    <= n_sq_n;
            r_sq_rem  <= n_sq_rem;
            r_sq_root <= n_sq_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v   <= 1'b0;
            r_dv_cnt <= '0;
        end else if (sq_hand) begin
            r_dv_v   <= 1'b1;
            r_dv_cnt <= DivIters;
            r_dv_len <= r_sq_root[30:0];
            r_dv_job <= r_sq_job;
            r_dv_neg <= r_sq_neg;
            r_dv_s   <= r_sq_s;
            r_dv_q   <= '0;
            for (int i = 0; i < 3; i++) begin
                r_dv_rem[i] <= {3'd0, dv_num[i][46:18]};
                r_dv_n[i]   <= dv_num[i][17:0];
            end
        end else if (dv_take) begin
            r_dv_v <= 1'b0;
        end else if (r_dv_v && (r_dv_cnt != 4'd0)) begin
            r_dv_cnt <= r_dv_cnt - 4'd1;
            r_dv_rem <= n_dv_rem;
            r_dv_n   <= n_dv_n;
            r_dv_q   <= n_dv_q;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_dv_len == 31'd0)  o_res[i] = '0;
            else if (r_dv_neg[i])   o_res[i] = ~r_dv_q[i] + 18'd1;
            else                    o_res[i] = r_dv_q[i];
        end
    end

    assign o_job   = r_dv_job;
    assign o_len   = r_dv_len;
    assign o_shift = r_dv_s;

endmodule

`default_nettype wire

// File: rtl/core/line_segment_box_extruder_top.sv
// Top level of the line segment box extruder: frame build and vertex emission.
//
// Input channel: one path segment per word (start, end, is_first) on i_valid /
// o_stall. Output channel: one vertex per word on o_valid / i_stall, 13 words
// for a first segment (arrow cap plus box) and 8 otherwise, the final word
// flagged with last. i_cfg_we writes line_width (Q8.8) from i_cfg_data; write
// it only while no segment is in flight.
// From the accepting input edge to the first vertex word, a segment passes
// three chained normalizers (4 fixed stages, the square root at two bits a
// cycle, then the divide), then 3 term stages, the sequencer load and the
// vertex register.
// Throughput is set by each normalizer's square root unit (one segment at a
// time); the vertex sequencer emits one vertex a cycle unless i_stall is set.
// Reset (synchronous, active low) empties every stage and sets line_width to
// 10.0. When the receiver stalls, the output word holds and the stall backs up
// stage by stage; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none

module line_segment_box_extruder_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lsbe_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output lsbe_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic [15:0]    i_cfg_data
);
    import lsbe_pkg::*;

    logic [15:0] r_line_width;

    t_job  job1, job2, job3;
    t_vec  vec1, vec2, vec3;
    logic  n1_rdy, n1_vld, n2_rdy, n2_vld, n3_rdy, n3_vld;
    t_job  n1_job, n2_job, n3_job;
    t_unit n1_res, n2_res, n3_res;
    logic [30:0] n1_len;
    logic [2:0]  n1_shift;
    logic [29:0] half_len;
    logic signed [35:0] pa, pb, pc, pd, nb, ud;

    logic e_adv, seq_free, seq_load, seq_emit, seq_done, out_free;

    logic             r_e1_v;
    t_job             r_e1_job;
    logic [2:0][35:0] r_e1_pf, r_e1_pu, r_e1_pr;
    logic             r_e2_v;
    t_job             r_e2_job;
    t_unit            r_e2_f, r_e2_u, r_e2_r;
    logic             r_e3_v;
    t_job             r_e3_job;
    t_unit            r_e3_u, r_e3_r;
    logic [2:0][32:0] r_e3_base;

    logic             r_sv;
    logic [3:0]       r_sk;
    logic             r_s_first;
    t_pt3             r_s_st, r_s_en;
    logic [2:0][32:0] r_s_base;
    t_unit            r_s_u, r_s_r;

    logic r_o_v;
    t_out r_o;

    logic [3:0]  slot;
    t_vtx        vinfo;
    logic [2:0][31:0] vpos;
    logic signed [34:0] pt, ut, rt, sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_line_width <= WidthRst;
        else if (i_cfg_we) r_line_width <= i_cfg_data;
    end

    // forward: end minus start
    always_comb begin
        job1       = '0;
        job1.st[0] = i_in.start_x;
        job1.st[1] = i_in.start_y;
        job1.st[2] = i_in.start_z;
        job1.en[0] = i_in.end_x;
        job1.en[1] = i_in.end_y;
        job1.en[2] = i_in.end_z;
        job1.first = i_in.is_first;
        for (int i = 0; i < 3; i++) begin
            vec1[i] = {{3{job1.en[i][31]}}, job1.en[i]} - {{3{job1.st[i][31]}}, job1.st[i]};
        end
    end

    assign o_stall = !n1_rdy;

    lsbe_norm u_norm_fwd (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(n1_rdy), .i_job(job1), .i_vec(vec1),
        .o_valid(n1_vld), .i_ready(n2_rdy), .o_job(n1_job), .o_res(n1_res),
        .o_len(n1_len), .o_shift(n1_shift)
    );

    // right = (fy, -fx, 0); cap offset from forward length
    assign half_len = n1_len[30:1];
    always_comb begin
        job2   = n1_job;
        job2.f = n1_res;
        if (!n1_job.first)                       job2.off = '0;
        else if (n1_shift != 3'd0)               job2.off = CapLimit;
        else if (half_len > {16'd0, CapLimit})   job2.off = CapLimit;
        else                                     job2.off = half_len[13:0];
        vec2[0] = {{17{n1_res[1][17]}}, n1_res[1]};
        vec2[1] = ~{{17{n1_res[0][17]}}, n1_res[0]} + 35'd1;
        vec2[2] = '0;
    end

    lsbe_norm u_norm_right (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(n1_vld), .o_ready(n2_rdy), .i_job(job2), .i_vec(vec2),
        .o_valid(n2_vld), .i_ready(n3_rdy), .o_job(n2_job), .o_res(n2_res),
        .o_len(), .o_shift()
    );

    // up = right x forward on the raw products
    always_comb begin
        job3   = n2_job;
        job3.r = n2_res;
        pa = $signed(n2_res[1]) * $signed(n2_job.f[2]);
        pb = $signed(n2_res[0]) * $signed(n2_job.f[2]);
        pc = $signed(n2_res[0]) * $signed(n2_job.f[1]);
        pd = $signed(n2_res[1]) * $signed(n2_job.f[0]);
        nb = -pb;
        ud = pc - pd;
        vec3[0] = pa[34:0];
        vec3[1] = nb[34:0];
        vec3[2] = ud[34:0];
    end

    lsbe_norm u_norm_up (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(n2_vld), .o_ready(n3_rdy), .i_job(job3), .i_vec(vec3),
        .o_valid(n3_vld), .i_ready(e_adv), .o_job(n3_job), .o_res(n3_res),
        .o_len(), .o_shift()
    );

    assign out_free = !r_o_v || !i_stall;
    assign seq_emit = r_sv && out_free;
    assign seq_done = seq_emit && (slot == LastSlot);
    assign seq_free = !r_sv || seq_done;
    assign seq_load = r_e3_v && seq_free;
    assign e_adv    = !r_e3_v || seq_load;

    // term products, rounding, cap base point
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
            r_e3_v <= 1'b0;
        end else if (e_adv) begin
            r_e1_v   <= n3_vld;
            r_e1_job <= n3_job;
            for (int i = 0; i < 3; i++) begin
                r_e1_pf[i] <= $signed(n3_job.f[i]) * $signed({1'b0, n3_job.off});
                r_e1_pu[i] <= $signed(n3_res[i]) * $signed({1'b0, r_line_width});
                r_e1_pr[i] <= $signed(n3_job.r[i]) * $signed({1'b0, r_line_width});
            end

            r_e2_v   <= r_e1_v;
            r_e2_job <= r_e1_job;
            for (int i = 0; i < 3; i++) begin
                r_e2_f[i] <= rnd_shr(r_e1_pf[i], 5'd16);
                r_e2_u[i] <= rnd_shr(r_e1_pu[i], 5'd17);
                r_e2_r[i] <= rnd_shr(r_e1_pr[i], 5'd17);
            end

            r_e3_v   <= r_e2_v;
            r_e3_job <= r_e2_job;
            r_e3_u   <= r_e2_u;
            r_e3_r   <= r_e2_r;
            for (int i = 0; i < 3; i++) begin
                r_e3_base[i] <= {r_e2_job.st[i][31], r_e2_job.st[i]}
                              + {{15{r_e2_f[i][17]}}, r_e2_f[i]};
            end
        end
    end

    // vertex sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_sk <= '0;
        end else if (seq_load) begin
            r_sv      <= 1'b1;
            r_sk      <= '0;
            r_s_first <= r_e3_job.first;
            r_s_st    <= r_e3_job.st;
            r_s_en    <= r_e3_job.en;
            r_s_base  <= r_e3_base;
            r_s_u     <= r_e3_u;
            r_s_r     <= r_e3_r;
        end else if (seq_done) begin
            r_sv <= 1'b0;
        end else if (seq_emit) begin
            r_sk <= r_sk + 4'd1;
        end
    end

    assign slot  = r_s_first ? r_sk : (r_sk + CapVerts);
    assign vinfo = vtx_info(slot);

    always_comb begin
        pt  = '0;
        ut  = '0;
        rt  = '0;
        sum = '0;
        for (int i = 0; i < 3; i++) begin
            case (vinfo.pt)
                PT_START: pt = {{3{r_s_st[i][31]}}, r_s_st[i]};
                PT_BASE:  pt = {{2{r_s_base[i][32]}}, r_s_base[i]};
                PT_END:   pt = {{3{r_s_en[i][31]}}, r_s_en[i]};
                default:  pt = '0;
            endcase
            case (vinfo.su)
                SG_POS:  ut = {{17{r_s_u[i][17]}}, r_s_u[i]};
                SG_NEG:  ut = -{{17{r_s_u[i][17]}}, r_s_u[i]};
                default: ut = '0;
            endcase
            case (vinfo.sr)
                SG_POS:  rt = {{17{r_s_r[i][17]}}, r_s_r[i]};
                SG_NEG:  rt = -{{17{r_s_r[i][17]}}, r_s_r[i]};
                default: rt = '0;
            endcase
            sum = pt + ut + rt;
            if (sum > 35'sd2147483647)       vpos[i] = 32'h7FFF_FFFF;
            else if (sum < -35'sd2147483648) vpos[i] = 32'h8000_0000;
            else                             vpos[i] = sum[31:0];
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (seq_emit) begin
            r_o_v               <= 1'b1;
            r_o.pos_x           <= vpos[0];
            r_o.pos_y           <= vpos[1];
            r_o.pos_z           <= vpos[2];
            r_o.tex_u           <= vinfo.tu;
            r_o.tex_v           <= vinfo.tv;
            r_o.vertex_number   <= r_sk;
            r_o.last            <= (slot == LastSlot);
        end else if (!i_stall) begin
            r_o_v <= 1'b0;
        end
    end

    assign o_valid = r_o_v;
    assign o_out   = r_o;

endmodule

`default_nettype wire
